>>> hw/rtl/ari_pkg.sv
`timescale 1ns / 1ps

package ari_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BASE_INTERVAL = 2'd0,
        CFG_HIGH_PERCENT  = 2'd1,
        CFG_LOW_PERCENT   = 2'd2
    } t_cfg_idx;

    // register reset values
    localparam logic [31:0] BASE_INTERVAL_RST = 32'd1000;
    localparam logic [6:0]  HIGH_PERCENT_RST  = 7'd10;
    localparam logic [6:0]  LOW_PERCENT_RST   = 7'd8;

    // full-scale load in percent
    localparam logic [6:0]  PCT_FULL          = 7'd100;

    // interval step is a multiply by 11 or 9 followed by a divide by this
    localparam logic [3:0]  INTERVAL_DIV      = 4'd10;

    typedef struct packed {
        logic        kind;
        logic [63:0] total_time;
        logic [63:0] busy_time;
    } t_in_item;

    typedef struct packed {
        logic [31:0] refresh_interval;
        logic        changed;
    } t_out_item;

endpackage

>>> hw/rtl/adaptive_refresh_interval.sv
// a restart beat is registered in r_done and then in the output register; an update beat
//   steps at most through CHECK, MUL, LDIV, DECIDE, IDIV and FIX, taking one bit of the load
//   quotient per cycle in the 65-bit restoring divider, then the bit-serial divide by ten
// throughput: one beat at a time; the next beat is taken in the cycle after the result is
//   written to the output register, which frees the input even while that result is stalled
// reset: synchronous active low; config and block state registers reset, state returns to idle
`timescale 1ns / 1ps

module adaptive_refresh_interval #(
    parameter int LOAD_FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ari_pkg::t_in_item    i_in_data,

    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ari_pkg::t_out_item   o_out_data,

    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // load is fixed point, 7 integer bits hold up to 100 percent
    localparam int LW = 7 + LOAD_FRAC_BITS;
    // 100 * 64-bit delta
    localparam int MW = 71;
    // 11 * 32-bit interval
    localparam int PW = 36;

    localparam logic [LW-1:0] LOAD_FULL = LW'(ari_pkg::PCT_FULL) << LOAD_FRAC_BITS;
    localparam logic [5:0]    LDIV_LAST = 6'(LW - 1);
    localparam logic [5:0]    IDIV_LAST = 6'(PW - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_LDIV   = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_IDIV   = 7'b0100000,
        S_FIX    = 7'b1000000
    } t_state;

    // result of the current beat waits for the output register
    logic                 r_done;

    t_state               r_state;
    t_state               n_state;

    // configuration
    logic [31:0]          r_base;
    logic [6:0]           r_high;
    logic [6:0]           r_low;

    // block state
    logic [31:0]          r_cur;
    logic [31:0]          r_prev;
    logic [LW-1:0]        r_last_load;
    logic [63:0]          r_last_total;
    logic [63:0]          r_last_busy;

    // datapath
    logic [63:0]          r_dt;
    logic [63:0]          r_db;
    logic [MW-1:0]        r_m;
    logic [63:0]          r_rem;
    logic [LW-1:0]        r_nsh;
    logic [LW-1:0]        r_load;
    logic [PW-1:0]        r_p;
    logic [3:0]           r_drem;
    logic                 r_grow;
    logic [5:0]           r_cnt;

    // output register
    logic                 r_out_valid;
    ari_pkg::t_out_item   r_out;

    logic                 in_acc;
    logic                 out_free;
    logic [LW-1:0]        hi_th;
    logic [LW-1:0]        lo_th;
    logic                 grow;
    logic                 shrink;
    logic [MW-1:0]        m_full;
    logic [64:0]          ld_rr;
    logic [64:0]          ld_diff;
    logic                 ld_ge;
    logic [4:0]           id_rr;
    logic                 id_ge;

    assign o_in_stall  = (r_state != S_IDLE) || r_done;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // thresholds in load units
    assign hi_th = LW'(r_high) << LOAD_FRAC_BITS;
    assign lo_th = LW'(r_low) << LOAD_FRAC_BITS;

    // both loads in a row above high grows, both below low shrinks (only above base)
    assign grow   = (r_load > hi_th) && (r_last_load > hi_th);
    assign shrink = (r_cur > r_base) && (r_load < lo_th) && (r_last_load < lo_th);

    // 100 * busy delta, second half of the add
    assign m_full = r_m + MW'({r_db, 2'b00});

    // one restoring step of the load division: shift in a numerator bit
    assign ld_rr   = {r_rem, r_nsh[LW-1]};
    assign ld_diff = ld_rr - {1'b0, r_dt};
    assign ld_ge   = (ld_rr >= {1'b0, r_dt});

    // one step of the divide by ten, quotient bits shift into r_p from below
    assign id_rr = {r_drem, r_p[PW-1]};
    assign id_ge = (id_rr >= 5'(ari_pkg::INTERVAL_DIV));

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= ari_pkg::BASE_INTERVAL_RST;
            r_high <= ari_pkg::HIGH_PERCENT_RST;
            r_low  <= ari_pkg::LOW_PERCENT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ari_pkg::CFG_BASE_INTERVAL: begin
                    r_base <= i_cfg_data;
                end
                ari_pkg::CFG_HIGH_PERCENT: begin
                    r_high <= i_cfg_data[6:0];
                end
                ari_pkg::CFG_LOW_PERCENT: begin
                    r_low <= i_cfg_data[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.kind) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // zero or saturated load skips the divider
                if (r_dt == 64'd0 || r_db >= r_dt) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_LDIV;
            end
            S_LDIV: begin
                if (r_cnt == LDIV_LAST) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (grow || shrink) begin
                    n_state = S_IDIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_IDIV: begin
                if (r_cnt == IDIV_LAST) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            // result goes out once the work is over: restart, no-change decide, or fix
            if (r_done) begin
                r_done <= !out_free;
            end else begin
                r_done <= (in_acc && !i_in_data.kind)
                       || (r_state == S_DECIDE && !grow && !shrink)
                       || (r_state == S_FIX);
            end
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= ari_pkg::BASE_INTERVAL_RST;
            r_last_load  <= LW'(ari_pkg::LOW_PERCENT_RST) << LOAD_FRAC_BITS;
            r_last_total <= 64'd0;
            r_last_busy  <= 64'd0;
        end else begin
            if (in_acc) begin
                r_last_total <= i_in_data.total_time;
                r_last_busy  <= i_in_data.busy_time;
                if (!i_in_data.kind) begin
                    r_cur       <= r_base;
                    r_last_load <= lo_th;
                end
            end
            if (r_state == S_DECIDE) begin
                r_last_load <= r_load;
            end
            if (r_state == S_FIX) begin
                if (r_grow) begin
                    // saturate at the top of the 32-bit range
                    r_cur <= (r_p[PW-1:32] != '0) ? '1 : r_p[31:0];
                end else begin
                    r_cur <= (r_p[31:0] > r_base) ? r_p[31:0] : r_base;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_prev <= r_cur;
            // deltas wrap modulo 2^64
            r_dt   <= i_in_data.total_time - r_last_total;
            r_db   <= i_in_data.busy_time - r_last_busy;
        end
        case (r_state)
            S_CHECK: begin
                if (r_dt == 64'd0) begin
                    r_load <= '0;
                end else if (r_db >= r_dt) begin
                    r_load <= LOAD_FULL;
                end
                // 96 * busy delta
                r_m <= MW'({r_db, 6'b0}) + MW'({r_db, 5'b0});
            end
            S_MUL: begin
                // top of the numerator is below the total delta, so no quotient bits
                // come from it; the low seven bits and the fraction zeros shift in
                r_rem <= m_full[MW-1:7];
                r_nsh <= LW'(m_full[6:0]) << LOAD_FRAC_BITS;
                r_cnt <= 6'd0;
            end
            S_LDIV: begin
                r_rem  <= ld_ge ? ld_diff[63:0] : ld_rr[63:0];
                r_nsh  <= r_nsh << 1;
                r_load <= {r_load[LW-2:0], ld_ge};
                r_cnt  <= r_cnt + 6'd1;
            end
            S_DECIDE: begin
                // 9 * interval, plus 2 * interval when growing
                r_p    <= PW'({r_cur, 3'b0}) + PW'(r_cur)
                        + (grow ? PW'({r_cur, 1'b0}) : PW'(0));
                r_grow <= grow;
                r_drem <= 4'd0;
                r_cnt  <= 6'd0;
            end
            S_IDIV: begin
                r_drem <= id_ge ? 4'(id_rr - 5'(ari_pkg::INTERVAL_DIV)) : id_rr[3:0];
                r_p    <= {r_p[PW-2:0], id_ge};
                r_cnt  <= r_cnt + 6'd1;
            end
            default: begin
            end
        endcase
    end

    // output register, parts the sequencer from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_done && out_free) begin
            r_out.refresh_interval <= r_cur;
            r_out.changed          <= (r_cur != r_prev);
        end
    end

`ifndef SYNTHESIS
    // a result only appears after the done step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_done))
        else $error("result raised without done step");

    // restart loads the base interval
    a_restart_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_data.kind) |=> (r_cur == $past(r_base)))
        else $error("restart did not load base interval");

    // load never exceeds full scale
    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_load <= LOAD_FULL))
        else $error("load above full scale");

    // load divider partial remainder stays below the divisor
    a_ldiv_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LDIV) |-> (r_rem < r_dt))
        else $error("load divider remainder out of range");

    // divide by ten remainder stays below ten
    a_idiv_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDIV) |-> (r_drem < ari_pkg::INTERVAL_DIV))
        else $error("interval divider remainder out of range");
`endif

endmodule
